// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the scheduler back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CHK(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("scheduler property violated");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
        else $error("scheduler forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr)

`endif

`endif

// ===== rtl/core/rrqts_pkg.sv =====
package rrqts_pkg;

    localparam int MAX_TASKS_DEF    = 16;
    localparam int QUANTUM_BITS_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int ID_W       = 4;
    localparam int QIN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_YIELD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ENABLE = 1'd1;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_TICK,
        OP_YIELD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  id;
        logic [QIN_W-1:0] quantum;
    } cmd_t;

endpackage

// ===== rtl/core/rrqts_item_if.sv =====
interface rrqts_item_if;
    logic                          valid;
    logic                          ready;
    logic [rrqts_pkg::FUNC_W-1:0]  func;
    logic [rrqts_pkg::ID_W-1:0]    task_id;
    logic [rrqts_pkg::QIN_W-1:0]   quantum;

    modport source (output valid, func, task_id, quantum, input ready);
    modport sink   (input valid, func, task_id, quantum, output ready);
endinterface

// ===== rtl/core/rrqts_result_if.sv =====
interface rrqts_result_if;
    logic                        valid;
    logic                        ready;
    logic [rrqts_pkg::ID_W-1:0]  current_task;
    logic                        has_current;
    logic                        switched;

    modport source (output valid, current_task, has_current, switched, input ready);
    modport sink   (input valid, current_task, has_current, switched, output ready);
endinterface

// ===== rtl/core/rrqts_front.sv =====
module rrqts_front #(
    parameter int MAX_TASKS = rrqts_pkg::MAX_TASKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rrqts_item_if.sink          item,
    output rrqts_pkg::cmd_t     cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready
);

    logic            valid_reg;
    logic            valid_next;
    rrqts_pkg::cmd_t cmd_reg;
    rrqts_pkg::cmd_t cmd_next;
    logic            accept;

    assign item.ready = !valid_reg || cmd_ready;
    assign accept     = item.valid && item.ready;
    assign cmd_valid  = valid_reg;
    assign cmd        = cmd_reg;

    // Decode the function code; an add of a slot outside the table becomes a no-op.
    always_comb
    begin
        cmd_next.id      = item.task_id;
        cmd_next.quantum = item.quantum;
        case (item.func)
            rrqts_pkg::FUNC_ADD:
            begin
                cmd_next.op = (int'(item.task_id) < MAX_TASKS) ? rrqts_pkg::OP_ADD
                                                               : rrqts_pkg::OP_NOP;
            end
            rrqts_pkg::FUNC_TICK:  cmd_next.op = rrqts_pkg::OP_TICK;
            rrqts_pkg::FUNC_YIELD: cmd_next.op = rrqts_pkg::OP_YIELD;
            default:               cmd_next.op = rrqts_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/core/rrqts_fifo.sv =====
module rrqts_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rrqts_pkg::cmd_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rrqts_pkg::cmd_t pop_data
);

    localparam int DEPTH = 2;

    rrqts_pkg::cmd_t entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/rrqts_back.sv =====
`include "assert_macros.svh"

module rrqts_back #(
    parameter int MAX_TASKS    = rrqts_pkg::MAX_TASKS_DEF,
    parameter int QUANTUM_BITS = rrqts_pkg::QUANTUM_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rrqts_pkg::cmd_t            cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic [rrqts_pkg::ID_W-1:0] idle_task,
    input  logic                       idle_enable,
    rrqts_result_if.source             result
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int ID_W   = rrqts_pkg::ID_W;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [QUANTUM_BITS-1:0] quant_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WR2
    } state_t;

    // Ring links and quanta, one write port and one registered read port each.
    slot_t  next_mem    [MAX_TASKS];
    quant_t quantum_mem [MAX_TASKS];
    slot_t  next_rd;
    quant_t quantum_rd;

    state_t         state_reg;
    state_t         state_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    slot_t          run_reg;
    slot_t          run_next;
    logic           nonempty_reg;
    logic           nonempty_next;
    quant_t         elapsed_reg;
    quant_t         elapsed_next;
    rrqts_pkg::op_t op_reg;
    slot_t          id_reg;
    quant_t         q_reg;
    slot_t          after_reg;
    logic           switched_reg;
    logic           switched_next;
    logic [ID_W-1:0] cur_task_reg;

    logic   pop;
    logic   next_we;
    slot_t  next_waddr;
    slot_t  next_wdata;
    logic   quantum_we;
    slot_t  quantum_waddr;
    quant_t quantum_wdata;
    quant_t elapsed_inc;
    slot_t  idle_slot;
    logic   idle_ok;

    assign cmd_ready   = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign pop         = cmd_valid && cmd_ready;
    assign elapsed_inc = elapsed_reg + quant_t'(1);
    assign idle_slot   = slot_t'(idle_task);
    assign idle_ok     = idle_enable && (int'(idle_task) < MAX_TASKS);

    assign result.valid        = out_valid_reg;
    assign result.current_task = cur_task_reg;
    assign result.has_current  = nonempty_reg;
    assign result.switched     = switched_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        run_next       = run_reg;
        nonempty_next  = nonempty_reg;
        elapsed_next   = elapsed_reg;
        switched_next  = 1'b0;
        next_we        = 1'b0;
        next_waddr     = run_reg;
        next_wdata     = id_reg;
        quantum_we     = 1'b0;
        quantum_waddr  = id_reg;
        quantum_wdata  = q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The read port has just returned the running slot's entries.
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                case (op_reg)
                    rrqts_pkg::OP_ADD:
                    begin
                        quantum_we = 1'b1;
                        if (!nonempty_reg)
                        begin
                            next_we       = 1'b1;
                            next_waddr    = id_reg;
                            run_next      = id_reg;
                            nonempty_next = 1'b1;
                        end
                        else if (id_reg != run_reg)
                        begin
                            next_we    = 1'b1;
                            state_next = S_WR2;
                        end
                    end
                    rrqts_pkg::OP_TICK:
                    begin
                        if (nonempty_reg)
                        begin
                            if (elapsed_inc >= quantum_rd)
                            begin
                                elapsed_next  = '0;
                                run_next      = next_rd;
                                switched_next = 1'b1;
                            end
                            else
                            begin
                                elapsed_next = elapsed_inc;
                            end
                        end
                    end
                    rrqts_pkg::OP_YIELD:
                    begin
                        if (nonempty_reg && idle_ok)
                        begin
                            quantum_we    = 1'b1;
                            quantum_waddr = idle_slot;
                            quantum_wdata = quantum_rd;
                            next_we       = 1'b1;
                            next_waddr    = idle_slot;
                            next_wdata    = next_rd;
                            run_next      = idle_slot;
                            switched_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WR2:
            begin
                // Second half of an insert: link the new slot to the old successor.
                next_we    = 1'b1;
                next_waddr = id_reg;
                next_wdata = after_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            run_reg       <= '0;
            nonempty_reg  <= 1'b0;
            elapsed_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            run_reg       <= run_next;
            nonempty_reg  <= nonempty_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= cmd.op;
            id_reg <= slot_t'(cmd.id);
            q_reg  <= quant_t'(cmd.quantum);
        end
        if (state_reg == S_EXEC)
        begin
            after_reg    <= next_rd;
            switched_reg <= switched_next;
            cur_task_reg <= ID_W'(run_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (quantum_we)
        begin
            quantum_mem[quantum_waddr] <= quantum_wdata;
        end
        next_rd    <= next_mem[run_reg];
        quantum_rd <= quantum_mem[run_reg];
    end

    `ASSERT_NEVER(a_ring_never_empties, clk, rst_n, $fell(nonempty_reg))
    `ASSERT_CHK(a_result_from_exec, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
    `ASSERT_CHK(a_wr2_follows_exec, clk, rst_n, (state_reg == S_WR2) |-> $past(state_reg == S_EXEC))
    `ASSERT_CHK(a_switch_needs_task, clk, rst_n, (out_valid_reg && switched_reg) |-> nonempty_reg)

endmodule

// ===== rtl/core/round_robin_quantum_task_scheduler_top.sv =====
// Channel   Port    Dir   Beat contents
// input     item    sink  func, task_id, quantum
// output    result  src   current_task, has_current, switched
// config    cfg_*   sink  idle_task (index 0), idle_enable (index 1), write only
//
// An item passes the execute unit's S_IDLE and S_EXEC states, and an add that
// splices a slot into a populated ring also passes S_WR2; the registered table
// read sets S_EXEC, and the link table's single write port adds S_WR2.
// Front register and a two-entry queue absorb input beats while the back end
// works or the result register waits. Reset is asynchronous and active low, and
// clears control state only; the slot tables are valid once written.
module round_robin_quantum_task_scheduler_top #(
    parameter int MAX_TASKS    = rrqts_pkg::MAX_TASKS_DEF,
    parameter int QUANTUM_BITS = rrqts_pkg::QUANTUM_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rrqts_item_if.sink                       item,
    rrqts_result_if.source                   result,
    input  logic                             cfg_we,
    input  logic [rrqts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrqts_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [rrqts_pkg::ID_W-1:0] idle_task_reg;
    logic                       idle_enable_reg;

    rrqts_pkg::cmd_t front_cmd;
    logic            front_valid;
    logic            front_ready;
    rrqts_pkg::cmd_t queue_cmd;
    logic            queue_valid;
    logic            queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_task_reg   <= '0;
            idle_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrqts_pkg::CFG_IDLE_TASK:   idle_task_reg   <= cfg_data[rrqts_pkg::ID_W-1:0];
                rrqts_pkg::CFG_IDLE_ENABLE: idle_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rrqts_front #(
        .MAX_TASKS (MAX_TASKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    rrqts_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    rrqts_back #(
        .MAX_TASKS    (MAX_TASKS),
        .QUANTUM_BITS (QUANTUM_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (queue_cmd),
        .cmd_valid   (queue_valid),
        .cmd_ready   (queue_ready),
        .idle_task   (idle_task_reg),
        .idle_enable (idle_enable_reg),
        .result      (result)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [rrqts_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 75;

    typedef logic [rrqts_pkg::ID_W-1:0]       id_t;
    typedef logic [rrqts_pkg::QIN_W-1:0]      qin_t;
    typedef logic [rrqts_pkg::CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [rrqts_pkg::FUNC_W-1:0] func;
        logic [rrqts_pkg::ID_W-1:0]   task_id;
        logic [rrqts_pkg::QIN_W-1:0]  quantum;
    } sched_cmd_t;

    typedef struct packed {
        logic [rrqts_pkg::ID_W-1:0] current_task;
        logic                       has_current;
        logic                       switched;
    } sched_view_t;

    logic clk;
    logic rst_n;
    logic                             cfg_we;
    logic [rrqts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rrqts_pkg::CFG_DATA_W-1:0] cfg_data;

    rrqts_item_if   sched_in ();
    rrqts_result_if sched_out ();

    round_robin_quantum_task_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (sched_in),
        .result    (sched_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the scheduler state, advanced once per accepted beat.
    logic [rrqts_pkg::ID_W-1:0]  link_tab    [rrqts_pkg::MAX_TASKS_DEF];
    logic [rrqts_pkg::QIN_W-1:0] quantum_tab [rrqts_pkg::MAX_TASKS_DEF];
    logic [rrqts_pkg::ID_W-1:0]  run_slot  = '0;
    logic                        ring_live = 1'b0;
    logic [rrqts_pkg::QIN_W-1:0] tick_count = '0;
    logic [rrqts_pkg::ID_W-1:0]  idle_slot = '0;
    logic                        idle_on   = 1'b0;

    sched_cmd_t  pending_cmds [$];
    sched_view_t expected_views [$];

    int unsigned err_count      = 0;
    int unsigned items_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned switch_count   = 0;
    int unsigned yield_switches = 0;
    int unsigned cfg_writes     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned idle_mode      = 0;
    logic        in_taken       = 1'b0;

    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic schedule_step(input sched_cmd_t cmd, output sched_view_t view);
        logic [rrqts_pkg::ID_W-1:0] cur;
        logic [rrqts_pkg::ID_W-1:0] after;
        logic                       sw;
        cur = run_slot;
        sw  = 1'b0;
        case (cmd.func)
            rrqts_pkg::FUNC_ADD:
            begin
                if (!ring_live)
                begin
                    run_slot = cmd.task_id;
                    link_tab[cmd.task_id] = cmd.task_id;
                    ring_live = 1'b1;
                end
                else
                begin
                    after = link_tab[cur];
                    link_tab[cur] = cmd.task_id;
                    link_tab[cmd.task_id] = after;
                end
                quantum_tab[cmd.task_id] = cmd.quantum;
            end
            rrqts_pkg::FUNC_TICK:
            begin
                if (ring_live)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= quantum_tab[cur])
                    begin
                        tick_count = '0;
                        run_slot = link_tab[cur];
                        sw = 1'b1;
                    end
                end
            end
            rrqts_pkg::FUNC_YIELD:
            begin
                // The count is deliberately left running across a yield.
                if (ring_live && idle_on)
                begin
                    quantum_tab[idle_slot] = quantum_tab[cur];
                    link_tab[idle_slot] = link_tab[cur];
                    run_slot = idle_slot;
                    sw = 1'b1;
                    yield_switches++;
                end
            end
            default: ;
        endcase
        if (sw)
            switch_count++;
        view = '{current_task: run_slot, has_current: ring_live, switched: sw};
    endtask

    always @(posedge clk)
    begin : monitor
        sched_view_t want;
        sched_view_t view;
        sched_cmd_t  cmd;
        logic        beat;
        if (rst_n)
        begin
            beat = cfg_we;
            if (sched_out.valid && sched_out.ready)
            begin
                beat = 1'b1;
                results_seen++;
                if (expected_views.size() == 0)
                    report_mismatch("result beat with nothing outstanding");
                else
                begin
                    want = expected_views.pop_front();
                    if (sched_out.current_task !== want.current_task)
                        report_mismatch($sformatf("result %0d current_task got %0d want %0d",
                            results_seen, sched_out.current_task, want.current_task));
                    if (sched_out.has_current !== want.has_current)
                        report_mismatch($sformatf("result %0d has_current got %b want %b",
                            results_seen, sched_out.has_current, want.has_current));
                    if (sched_out.switched !== want.switched)
                        report_mismatch($sformatf("result %0d switched got %b want %b",
                            results_seen, sched_out.switched, want.switched));
                end
            end
            in_taken = sched_in.valid && sched_in.ready;
            if (in_taken)
            begin
                beat = 1'b1;
                items_taken++;
                cmd = '{func: sched_in.func, task_id: sched_in.task_id,
                        quantum: sched_in.quantum};
                schedule_step(cmd, view);
                expected_views.push_back(view);
            end
            if (cfg_we)
            begin
                cfg_writes++;
                if (cfg_index == rrqts_pkg::CFG_IDLE_TASK)
                    idle_slot = cfg_data[rrqts_pkg::ID_W-1:0];
                else if (cfg_index == rrqts_pkg::CFG_IDLE_ENABLE)
                    idle_on = cfg_data[0];
            end
            quiet_cycles = beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                    WATCHDOG_LIMIT, expected_views.size());
                $display("FAIL round_robin_quantum_task_scheduler_top");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : item_driver
        sched_cmd_t nxt;
        if (rst_n && (!sched_in.valid || in_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                sched_in.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 && idle_mode != 0 &&
                     $urandom_range(0, idle_mode == 1 ? 9 : 2) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                sched_in.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                sched_in.valid   <= 1'b1;
                sched_in.func    <= nxt.func;
                sched_in.task_id <= nxt.task_id;
                sched_in.quantum <= nxt.quantum;
            end
            else
                sched_in.valid <= 1'b0;
        end
    end

    // The one long hold lets the input side back up until the block stalls it.
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                sched_out.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 300 && pending_cmds.size() >= 20)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                sched_out.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                sched_out.ready <= 1'b0;
            end
            else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 2) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                sched_out.ready <= 1'b0;
            end
            else
                sched_out.ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic [rrqts_pkg::FUNC_W-1:0] func,
                              input logic [rrqts_pkg::ID_W-1:0] id,
                              input logic [rrqts_pkg::QIN_W-1:0] q);
        pending_cmds.push_back('{func: func, task_id: id, quantum: q});
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || sched_in.valid || expected_views.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [rrqts_pkg::CFG_DATA_W-1:0] slot,
                             input logic [rrqts_pkg::CFG_DATA_W-1:0] enable_word);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rrqts_pkg::CFG_IDLE_TASK;
        cfg_data  <= slot;
        @(negedge clk);
        cfg_index <= rrqts_pkg::CFG_IDLE_ENABLE;
        cfg_data  <= enable_word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic sched_cmd_t random_item();
        sched_cmd_t  cmd;
        int unsigned pick;
        int unsigned qpick;
        pick  = $urandom_range(0, 99);
        qpick = $urandom_range(0, 99);
        cmd.task_id = id_t'($urandom_range(0, rrqts_pkg::MAX_TASKS_DEF - 1));
        // Small quanta keep the ring turning; large ones are kept rare.
        if (qpick < 65)
            cmd.quantum = qin_t'($urandom_range(0, 3));
        else if (qpick < 90)
            cmd.quantum = qin_t'($urandom_range(4, 12));
        else if (qpick < 97)
            cmd.quantum = qin_t'($urandom_range(0, 16'hFFFF));
        else
            cmd.quantum = 16'hFFFF;
        if (pick < 28)
            cmd.func = rrqts_pkg::FUNC_ADD;
        else if (pick < 80)
            cmd.func = rrqts_pkg::FUNC_TICK;
        else if (pick < 96)
            cmd.func = rrqts_pkg::FUNC_YIELD;
        else
            cmd.func = FUNC_SPARE;
        return cmd;
    endfunction

    initial
    begin : stimulus
        logic [rrqts_pkg::CFG_DATA_W-1:0] slot;
        logic [rrqts_pkg::CFG_DATA_W-1:0] enable_word;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rrqts_pkg::CFG_IDLE_TASK;
        cfg_data = '0;
        sched_in.valid = 1'b0;
        sched_in.func = rrqts_pkg::FUNC_ADD;
        sched_in.task_id = '0;
        sched_in.quantum = '0;
        sched_out.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty ring first, with the idle task still disabled from reset.
        idle_mode = 2;
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(FUNC_SPARE, 4'd15, 16'hFFFF);
        queue_item(rrqts_pkg::FUNC_ADD, 4'd5, 16'd2);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_ADD, 4'd15, 16'd0);
        queue_item(rrqts_pkg::FUNC_ADD, 4'd5, 16'd1);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(FUNC_SPARE, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_ADD, 4'd0, 16'hFFFF);

        configure(4'd15, 4'd1);
        idle_mode = 0;
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);

        configure(4'd0, 4'd0);
        idle_mode = 1;
        queue_item(rrqts_pkg::FUNC_YIELD, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_ADD, 4'd10, 16'd3);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);
        queue_item(rrqts_pkg::FUNC_TICK, 4'd0, 16'd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                slot = 4'd15;
            else if (p == 1)
                slot = 4'd0;
            else
                slot = cfg_word_t'($urandom_range(0, rrqts_pkg::MAX_TASKS_DEF - 1));
            enable_word = cfg_word_t'($urandom_range(0, 15));
            if (p == 2)
                enable_word[0] = 1'b0;
            else if (p < 2 || $urandom_range(0, 3) != 0)
                enable_word[0] = 1'b1;
            configure(slot, enable_word);
            idle_mode = (p >= RANDOM_PHASES - 2) ? 0 : $urandom_range(0, 2);
            repeat (PHASE_ITEMS) pending_cmds.push_back(random_item());
        end

        drain();
        $display("Run covered %0d items and %0d results across %0d register writes.",
            items_taken, results_seen, cfg_writes);
        $display("Task switches: %0d, of which %0d came from yields; %0d mismatches.",
            switch_count, yield_switches, err_count);
        if (err_count == 0)
            $display("PASS round_robin_quantum_task_scheduler_top");
        else
            $display("FAIL round_robin_quantum_task_scheduler_top");
        $finish;
    end

endmodule
